/* rtl/core/fot_pkg.sv */
// Shared types, codes and constants of the FAT32 file offset translator.
// No dependencies; every module of the translator imports this package.
package fot_pkg;

   // Request kinds on the input channel.
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_REPLY = 2'd1;
   localparam logic [1:0] KIND_NEXT  = 2'd2;

   // Request codes on the result channel.
   localparam logic [1:0] REQ_NONE = 2'd0;
   localparam logic [1:0] REQ_FAT  = 2'd1;
   localparam logic [1:0] REQ_DATA = 2'd2;

   // Status codes on the result channel.
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_END        = 2'd1;
   localparam logic [1:0] ST_FREE       = 2'd2;
   localparam logic [1:0] ST_UNEXPECTED = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SECTOR_BYTES    = 2'd0;
   localparam logic [1:0] CSR_CLUSTER_SECTORS = 2'd1;
   localparam logic [1:0] CSR_FAT_START       = 2'd2;
   localparam logic [1:0] CSR_DATA_START      = 2'd3;

   localparam logic [31:0] CHAIN_END  = 32'hffff_fff8;
   localparam logic [19:0] OFFSET_MAX = 20'hf_ffff;

   typedef struct packed {
      logic [12:0] sector_bytes;
      logic [7:0]  cluster_sectors;
      logic [15:0] fat_start_sector;
      logic [31:0] data_start_sector;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] value;
      logic [31:0] position;
   } item_type;

   typedef struct packed {
      logic        load;
      logic [1:0]  request;
      logic [47:0] address;
      logic [1:0]  status;
   } result_type;

   // Operands of the shared multiply-accumulate unit.
   typedef struct packed {
      logic [32:0] a;      // signed multiplicand
      logic [15:0] b;      // unsigned multiplier
      logic [47:0] c;      // addend
      logic        shift;  // shift the product up by 32 bits
   } mac_op_type;

   // Phases of the chain walk.
   typedef enum logic [5:0] {
      PH_IDLE  = 6'b000001,
      PH_SEEK  = 6'b000010,
      PH_READY = 6'b000100,
      PH_STEP  = 6'b001000,
      PH_END   = 6'b010000,
      PH_ERROR = 6'b100000
   } phase_type;

   // Steps of the sequencer that drives the shared unit.
   typedef enum logic [9:0] {
      SQ_IDLE  = 10'b00_0000_0001,
      SQ_CSIZE = 10'b00_0000_0010,
      SQ_EVAL  = 10'b00_0000_0100,
      SQ_WALK  = 10'b00_0000_1000,
      SQ_FAT   = 10'b00_0001_0000,
      SQ_BASE1 = 10'b00_0010_0000,
      SQ_BASE2 = 10'b00_0100_0000,
      SQ_BASE3 = 10'b00_1000_0000,
      SQ_EMIT  = 10'b01_0000_0000,
      SQ_SPARE = 10'b10_0000_0000
   } seq_state_type;

endpackage

/* rtl/core/fot_mac.sv */
// Shared multiply-accumulate unit of the translator: r = (a * b << 0|32) + c, modulo 2^48.
// Depends on fot_pkg for the operand struct.
module fot_mac
   import fot_pkg::*;
(
   input  mac_op_type  op,
   output logic [47:0] result
);

   logic signed [32:0] a_s;
   logic signed [16:0] b_s;
   logic signed [49:0] product;
   logic [47:0]        shifted;

   assign a_s     = $signed(op.a);
   assign b_s     = $signed({1'b0, op.b});
   assign product = a_s * b_s;
   assign shifted = op.shift ? {product[15:0], 32'd0} : product[47:0];
   assign result  = shifted + op.c;

endmodule

/* rtl/core/fot_seq.sv */
// Sequencer of the translator: chain-walk phase, cursor state, cached cluster size and
// cluster base address, all multiplications through one fot_mac. Depends on fot_pkg and fot_mac.
module fot_seq
   import fot_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_accept,
   input  item_type   item,
   output logic       in_ready,
   input  cfg_type    cfg,
   input  logic       cfg_write,
   input  logic       out_free,
   output result_type res
);

   seq_state_type state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic [27:0]   cluster_ff, cluster_in;
   logic [19:0]   offset_ff, offset_in;
   logic [31:0]   seek_ff, seek_in;
   logic [19:0]   csize_ff, csize_in;
   logic          csize_ok_ff, csize_ok_in;
   logic [47:0]   base_ff, base_in;
   logic          base_ok_ff, base_ok_in;
   logic [47:0]   sec_ff, sec_in;
   item_type      item_ff, item_in;

   mac_op_type    op;
   logic [47:0]   mac_r;
   logic [28:0]   rel;

   fot_mac u_mac (
      .op     (op),
      .result (mac_r)
   );

   // Cluster number less two, as a signed value so that clusters 0 and 1 wrap.
   assign rel      = {1'b0, cluster_ff} - 29'd2;
   assign in_ready = (state_ff == SQ_IDLE);

   always_comb begin
      op = '{a: {13'd0, offset_ff}, b: 16'd1, c: base_ff, shift: 1'b0};
      case (state_ff)
         SQ_CSIZE: begin
            op = '{a: {20'd0, cfg.sector_bytes}, b: {8'd0, cfg.cluster_sectors},
                   c: 48'd0, shift: 1'b0};
         end
         SQ_FAT: begin
            op = '{a: {17'd0, cfg.fat_start_sector}, b: {3'd0, cfg.sector_bytes},
                   c: {18'd0, cluster_ff, 2'b00}, shift: 1'b0};
         end
         SQ_BASE1: begin
            op = '{a: {{4{rel[28]}}, rel}, b: {8'd0, cfg.cluster_sectors},
                   c: {16'd0, cfg.data_start_sector}, shift: 1'b0};
         end
         SQ_BASE2: begin
            op = '{a: {1'b0, sec_ff[31:0]}, b: {3'd0, cfg.sector_bytes},
                   c: 48'd0, shift: 1'b0};
         end
         SQ_BASE3: begin
            op = '{a: {17'd0, sec_ff[47:32]}, b: {3'd0, cfg.sector_bytes},
                   c: base_ff, shift: 1'b1};
         end
         default: begin
            op = '{a: {13'd0, offset_ff}, b: 16'd1, c: base_ff, shift: 1'b0};
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      cluster_in  = cluster_ff;
      offset_in   = offset_ff;
      seek_in     = seek_ff;
      csize_in    = csize_ff;
      csize_ok_in = csize_ok_ff;
      base_in     = base_ff;
      base_ok_in  = base_ok_ff;
      sec_in      = sec_ff;
      item_in     = item_ff;
      res         = '{load: 1'b0, request: REQ_NONE, address: 48'd0, status: ST_OK};

      case (state_ff)
         SQ_IDLE: begin
            if (in_accept) begin
               item_in  = item;
               state_in = csize_ok_ff ? SQ_EVAL : SQ_CSIZE;
            end
         end
         SQ_CSIZE: begin
            csize_in    = (mac_r[47:20] != 28'd0) ? OFFSET_MAX : mac_r[19:0];
            csize_ok_in = 1'b1;
            state_in    = SQ_EVAL;
         end
         SQ_EVAL: begin
            case (item_ff.kind)
               KIND_START: begin
                  cluster_in = item_ff.value[27:0];
                  seek_in    = item_ff.position;
                  offset_in  = 20'd0;
                  base_ok_in = 1'b0;
                  state_in   = SQ_WALK;
               end
               KIND_REPLY: begin
                  if (phase_ff == PH_SEEK || phase_ff == PH_STEP) begin
                     if (item_ff.value == 32'd0) begin
                        if (out_free) begin
                           res.load   = 1'b1;
                           res.status = ST_FREE;
                           phase_in   = PH_ERROR;
                           state_in   = SQ_IDLE;
                        end
                     end else if (item_ff.value >= CHAIN_END) begin
                        if (out_free) begin
                           res.load   = 1'b1;
                           res.status = ST_END;
                           phase_in   = PH_END;
                           state_in   = SQ_IDLE;
                        end
                     end else begin
                        cluster_in = item_ff.value[27:0];
                        base_ok_in = 1'b0;
                        if (phase_ff == PH_SEEK) begin
                           seek_in  = seek_ff - {12'd0, csize_ff};
                           state_in = SQ_WALK;
                        end else begin
                           offset_in = 20'd0;
                           phase_in  = PH_READY;
                           state_in  = SQ_BASE1;
                        end
                     end
                  end else if (out_free) begin
                     res.load   = 1'b1;
                     res.status = ST_UNEXPECTED;
                     state_in   = SQ_IDLE;
                  end
               end
               KIND_NEXT: begin
                  if (phase_ff == PH_READY) begin
                     if (offset_ff >= csize_ff) begin
                        phase_in = PH_STEP;
                        state_in = SQ_FAT;
                     end else if (!base_ok_ff) begin
                        state_in = SQ_BASE1;
                     end else if (out_free) begin
                        // Same cluster: the byte address is the cached base plus offset.
                        res.load    = 1'b1;
                        res.request = REQ_DATA;
                        res.address = mac_r;
                        offset_in   = offset_ff + 20'd1;
                        state_in    = SQ_IDLE;
                     end
                  end else if (out_free) begin
                     res.load = 1'b1;
                     if (phase_ff == PH_END) begin
                        res.status = ST_END;
                     end else if (phase_ff == PH_ERROR) begin
                        res.status = ST_FREE;
                     end else begin
                        res.status = ST_UNEXPECTED;
                     end
                     state_in = SQ_IDLE;
                  end
               end
               default: begin
                  if (out_free) begin
                     res.load   = 1'b1;
                     res.status = ST_UNEXPECTED;
                     state_in   = SQ_IDLE;
                  end
               end
            endcase
         end
         SQ_WALK: begin
            if (seek_ff >= {12'd0, csize_ff}) begin
               phase_in = PH_SEEK;
               state_in = SQ_FAT;
            end else if (out_free) begin
               // Less than one cluster left: the remainder is the offset in this cluster.
               res.load  = 1'b1;
               offset_in = seek_ff[19:0];
               phase_in  = PH_READY;
               state_in  = SQ_IDLE;
            end
         end
         SQ_FAT: begin
            if (out_free) begin
               res.load    = 1'b1;
               res.request = REQ_FAT;
               res.address = mac_r;
               state_in    = SQ_IDLE;
            end
         end
         SQ_BASE1: begin
            sec_in   = mac_r;
            state_in = SQ_BASE2;
         end
         SQ_BASE2: begin
            base_in  = mac_r;
            state_in = SQ_BASE3;
         end
         SQ_BASE3: begin
            base_in    = mac_r;
            base_ok_in = 1'b1;
            state_in   = SQ_EMIT;
         end
         SQ_EMIT: begin
            if (out_free) begin
               res.load    = 1'b1;
               res.request = REQ_DATA;
               res.address = mac_r;
               offset_in   = offset_ff + 20'd1;
               state_in    = SQ_IDLE;
            end
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase

      // Any register write makes the cached cluster size and base address stale.
      if (cfg_write) begin
         csize_ok_in = 1'b0;
         base_ok_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= SQ_IDLE;
         phase_ff    <= PH_IDLE;
         cluster_ff  <= 28'd0;
         offset_ff   <= 20'd0;
         seek_ff     <= 32'd0;
         csize_ok_ff <= 1'b0;
         base_ok_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         cluster_ff  <= cluster_in;
         offset_ff   <= offset_in;
         seek_ff     <= seek_in;
         csize_ok_ff <= csize_ok_in;
         base_ok_ff  <= base_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      csize_ff <= csize_in;
      base_ff  <= base_in;
      sec_ff   <= sec_in;
      item_ff  <= item_in;
   end

endmodule

/* rtl/core/fat32_file_offset_translator.sv */
// Top level of the FAT32 file offset translator: stream ports, configuration registers
// and the result register. Depends on fot_pkg and fot_seq.
//
// Use: send a start request (tuser kind 0) with the first cluster and the file byte
// cursor. While a whole cluster of the cursor remains, each result asks for a FAT entry
// (request 1); answer it with a reply request (kind 1) carrying the raw entry. Once the
// walk is done, each next-byte request (kind 2) returns the storage address of that
// byte (request 2), or first a FAT request when the cluster is used up. End of chain
// and a free entry are reported in status; no byte address follows until a new start.
// Every request gives exactly one result.
// Timing: the block takes one request at a time and drops req_tready while it works.
// A next byte inside the current cluster is answered from the cached base address.
// The first byte of a new cluster first builds the cluster base address in three passes
// of the shared multiply-accumulate unit. After a register write the cluster size is
// recomputed once, on the next request.
// Results sit in an output register; while rsp_tready is low the block still accepts
// the next request and finishes it, then waits until the register frees up.
// Reset (synchronous) restores the register defaults and the idle phase; the block is
// ready in the first cycle after reset.
module fat32_file_offset_translator
   import fot_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // value [31:0], position [63:32]
   input  logic [1:0]  req_tuser,   // kind [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // address [47:0]
   output logic [3:0]  rsp_tuser,   // request [1:0], status [3:2]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [47:0] rsp_tdata_ff, rsp_tdata_in;
   logic [3:0]  rsp_tuser_ff, rsp_tuser_in;
   logic        out_free;
   logic        in_accept;
   item_type    item;
   result_type  res;

   assign in_accept = req_tvalid && req_tready;
   assign out_free  = !rsp_tvalid_ff || rsp_tready;
   assign item      = '{kind: req_tuser, value: req_tdata[31:0], position: req_tdata[63:32]};

   fot_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .item      (item),
      .in_ready  (req_tready),
      .cfg       (cfg_ff),
      .cfg_write (csr_we),
      .out_free  (out_free),
      .res       (res)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SECTOR_BYTES:    cfg_in.sector_bytes      = csr_wdata[12:0];
            CSR_CLUSTER_SECTORS: cfg_in.cluster_sectors   = csr_wdata[7:0];
            CSR_FAT_START:       cfg_in.fat_start_sector  = csr_wdata[15:0];
            CSR_DATA_START:      cfg_in.data_start_sector = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (res.load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = res.address;
         rsp_tuser_in  = {res.status, res.request};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= '{sector_bytes: 13'd512, cluster_sectors: 8'd8,
                            fat_start_sector: 16'd32, data_start_sector: 32'd0};
         rsp_tvalid_ff <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef NO_ASSERTIONS
   // A finished result never lands in the same cycle as a new request is taken.
   a_load_not_idle: assert property (@(posedge clock) disable iff (reset)
      res.load |-> !req_tready)
      else $error("result produced while the sequencer is idle");

   // A waiting result is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !res.load)
      else $error("pending result overwritten");

   // Only one request is in the block at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      in_accept |=> !req_tready)
      else $error("request accepted while another is in progress");

   // A result without a storage access carries a zero address.
   a_none_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (res.load && res.request == REQ_NONE) |-> (res.address == 48'd0))
      else $error("non-zero address on a result without a request");
`endif

endmodule
